// ===== rtl/stereo_mid_polynomial_predictor_unit_macros.svh =====
// Assertion macros shared by the stereo mid predictor checker.
`ifndef STEREO_MID_POLYNOMIAL_PREDICTOR_UNIT_MACROS_SVH
`define STEREO_MID_POLYNOMIAL_PREDICTOR_UNIT_MACROS_SVH

// Implication checked only while out of reset.
`define SMPP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("smpp assertion failed");

// Implication checked at every edge, reset included.
`define SMPP_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("smpp assertion failed");

`endif

// ===== rtl/smpp_pkg.sv =====
// Package: widths, codes and constants of the stereo mid polynomial predictor.
`default_nettype none
package smpp_pkg;

    // Field widths
    localparam int SAMPLE_W   = 9;
    localparam int RESIDUAL_W = 12;
    localparam int OUT_W      = 12;
    localparam int POS_W      = 2;
    localparam int CALC_W     = 14;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 16;

    // Saturation bounds of a decoded sample
    localparam logic signed [CALC_W-1:0] SAMPLE_MAX = 14'sd255;
    localparam logic signed [CALC_W-1:0] SAMPLE_MIN = -14'sd255;

    // Predictor order by position in the stream
    typedef enum logic [POS_W-1:0] {
        POS_ORDER0 = 2'd0,
        POS_ORDER1 = 2'd1,
        POS_ORDER2 = 2'd2,
        POS_STEADY = 2'd3
    } pos_t;

    // Direction register codes
    typedef enum logic {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } dir_t;

endpackage
`default_nettype wire

// ===== rtl/stereo_mid_polynomial_predictor_unit.sv =====
// Stereo mid polynomial predictor: encode L/R to residuals or decode residuals.
// Datapath: an accepted item passes the input register, then the result register;
// the result is registered and held until it is taken.
// Throughput: one item per cycle while m_tready is high; history updates as each item is processed.
// The next item sees the history left by the previous one with no bubble.
// Reset (aresetn low, synchronous): both stages empty, history zero,
// stream position zero, direction encode.
`default_nettype none
module stereo_mid_polynomial_predictor_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration: direction (0 encode, 1 decode)
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic                           cfg_data,
    // input items
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [8:0] left_sample, [17:9] right_sample, [29:18] residual_in, [31:30] zero
    input  wire logic [smpp_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] start_of_stream
    input  wire logic                           s_tuser,
    // result items
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [11:0] out_value, [15:12] zero
    output logic [smpp_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int SW = smpp_pkg::SAMPLE_W;
    localparam int RW = smpp_pkg::RESIDUAL_W;
    localparam int CW = smpp_pkg::CALC_W;
    localparam int OW = smpp_pkg::OUT_W;

    // Control registers
    logic               in_valid_reg, in_valid_next;
    logic               out_valid_reg, out_valid_next;
    smpp_pkg::dir_t     direction_reg;
    smpp_pkg::pos_t     pos_reg, pos_next;

    // Payload registers
    logic                   in_sos_reg;
    logic signed [SW-1:0]   in_left_reg, in_right_reg;
    logic signed [RW-1:0]   in_res_reg;
    logic signed [SW-1:0]   hist_reg [3];
    logic signed [SW-1:0]   hist_next [3];
    logic [OW-1:0]          out_value_reg;

    // Datapath signals
    logic                   advance, in_accept, process;
    smpp_pkg::pos_t         pos_eff;
    logic signed [CW-1:0]   h0, h1, h2, est;
    logic signed [SW:0]     lr_sum;
    logic signed [SW-1:0]   merged;
    logic signed [CW-1:0]   enc_val, dec_sum, dec_val, val;
    logic signed [SW-1:0]   store_val;

    // Handshake
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;
    assign process   = in_valid_reg && advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(smpp_pkg::M_TDATA_W - OW){1'b0}}, out_value_reg};

    // Stage valid flags
    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
        end
    end

    // Prediction from history; start flag forces order zero
    always_comb begin
        pos_eff = in_sos_reg ? smpp_pkg::POS_ORDER0 : pos_reg;
        h0 = CW'(hist_reg[0]);
        h1 = CW'(hist_reg[1]);
        h2 = CW'(hist_reg[2]);
        case (pos_eff)
            smpp_pkg::POS_ORDER0: est = '0;
            smpp_pkg::POS_ORDER1: est = h0;
            smpp_pkg::POS_ORDER2: est = (h1 <<< 1) - h0;
            smpp_pkg::POS_STEADY: est = (h2 <<< 1) + h2 - (h1 <<< 1) - h1 + h0;
            default:              est = '0;
        endcase
    end

    // Encode: floor((L+R)/2) minus estimate; decode: residual plus estimate, saturated
    always_comb begin
        lr_sum  = (SW+1)'(in_left_reg) + (SW+1)'(in_right_reg);
        merged  = SW'(lr_sum >>> 1);
        enc_val = CW'(merged) - est;
        dec_sum = CW'(in_res_reg) + est;
        if (dec_sum > smpp_pkg::SAMPLE_MAX) begin
            dec_val = smpp_pkg::SAMPLE_MAX;
        end else if (dec_sum < smpp_pkg::SAMPLE_MIN) begin
            dec_val = smpp_pkg::SAMPLE_MIN;
        end else begin
            dec_val = dec_sum;
        end
        if (direction_reg == smpp_pkg::DIR_DECODE) begin
            val       = dec_val;
            store_val = SW'(dec_val);
        end else begin
            val       = enc_val;
            store_val = merged;
        end
    end

    // History fill during start-up, shift in steady state
    always_comb begin
        hist_next = hist_reg;
        pos_next  = pos_reg;
        if (process) begin
            case (pos_eff)
                smpp_pkg::POS_ORDER0: begin
                    hist_next[0] = store_val;
                    pos_next     = smpp_pkg::POS_ORDER1;
                end
                smpp_pkg::POS_ORDER1: begin
                    hist_next[1] = store_val;
                    pos_next     = smpp_pkg::POS_ORDER2;
                end
                smpp_pkg::POS_ORDER2: begin
                    hist_next[2] = store_val;
                    pos_next     = smpp_pkg::POS_STEADY;
                end
                smpp_pkg::POS_STEADY: begin
                    hist_next[0] = hist_reg[1];
                    hist_next[1] = hist_reg[2];
                    hist_next[2] = store_val;
                    pos_next     = smpp_pkg::POS_STEADY;
                end
                default: begin
                    pos_next = pos_reg;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            direction_reg <= smpp_pkg::DIR_ENCODE;
            pos_reg       <= smpp_pkg::POS_ORDER0;
            hist_reg[0]   <= '0;
            hist_reg[1]   <= '0;
            hist_reg[2]   <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            hist_reg      <= hist_next;
            if (cfg_valid && cfg_ready) begin
                direction_reg <= smpp_pkg::dir_t'(cfg_data);
            end
        end
    end

    // Input item register
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_sos_reg   <= s_tuser;
            in_left_reg  <= s_tdata[SW-1:0];
            in_right_reg <= s_tdata[2*SW-1:SW];
            in_res_reg   <= s_tdata[2*SW+RW-1:2*SW];
        end
    end

    // Result item register
    always_ff @(posedge aclk) begin
        if (process) begin
            out_value_reg <= val[OW-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/smpp_checker.sv =====
// Port-level checker for the stereo mid predictor, bound to the top level.
`default_nettype none
`include "stereo_mid_polynomial_predictor_unit_macros.svh"
module smpp_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [smpp_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result holds its value
    `SMPP_ASSERT_IMPL(a_hold, aclk, aresetn, m_tvalid && !m_tready, ##1 (m_tvalid && $stable(m_tdata)))

    // Reset empties the result stage
    `SMPP_ASSERT_ALWAYS(a_reset, aclk, !aresetn, ##1 !m_tvalid)

    // An accepted item leads to a valid result on the output
    `SMPP_ASSERT_IMPL(a_latency, aclk, aresetn, s_tvalid && s_tready, ##2 m_tvalid)

    // Padding above the result field stays zero
    `SMPP_ASSERT_IMPL(a_pad, aclk, aresetn, m_tvalid, m_tdata[smpp_pkg::M_TDATA_W-1:smpp_pkg::OUT_W] == '0)

endmodule

bind stereo_mid_polynomial_predictor_unit smpp_checker u_smpp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
